@@ design/srf_pkg.sv @@
// Package for the signed radix formatter: microcode word layout, step names,
// datapath operation and jump condition codes, and fixed field widths.
// No dependencies; every other design file imports it.
package srf_pkg;

    localparam int LEN_W     = 5;   // base_length register width
    localparam int SYMS_W    = 64;  // each symbol bank register width
    localparam int CFG_W     = 64;  // configuration write data width
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 32;  // value port width
    localparam int SYM_W     = 8;   // one symbol byte
    localparam int SYM_N     = 16;  // symbol table slots
    localparam int SYM_IDX_W = 4;
    localparam int DIV_BITS  = 8;   // dividend bits retired per divide cycle
    localparam int STEP_W    = 4;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE     = 4'd0;
    localparam t_step STEP_LEN      = 4'd1;
    localparam t_step STEP_SYM      = 4'd2;
    localparam t_step STEP_BADQ     = 4'd3;
    localparam t_step STEP_DIV_INIT = 4'd4;
    localparam t_step STEP_DIV      = 4'd5;
    localparam t_step STEP_PUSH     = 4'd6;
    localparam t_step STEP_SIGN     = 4'd7;
    localparam t_step STEP_DIG      = 4'd8;
    localparam t_step STEP_DONE     = 4'd9;
    localparam t_step STEP_INV      = 4'd10;
    localparam t_step STEP_INV_DONE = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CHK_INIT,
        OP_CHK_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_PUSH,
        OP_EMIT_SIGN,
        OP_EMIT_DIG,
        OP_EMIT_INV
    } t_dp_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_LEN_BAD,
        C_CHK_MORE,
        C_BAD,
        C_DIV_MORE,
        C_MAG_NZ,
        C_SIGN_WAIT,
        C_DIG_LOOP,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_dp_op op;
        t_cond  cond;
        t_step  target;
    } t_uword;

    typedef struct packed {
        t_dp_op op;
        logic   accept;
    } t_dp_ctrl;

    typedef struct packed {
        logic len_bad;
        logic sym_bad;
        logic chk_more;
        logic div_more;
        logic mag_nz;
        logic out_free;
        logic neg;
        logic nd_one;
    } t_dp_stat;

endpackage

@@ design/signed_radix_formatter.sv @@
// Channel   | valid   | stall   | payload
// ----------+---------+---------+-------------------------------------
// input     | i_valid | o_stall | i_value
// output    | o_valid | i_stall | o_symbol, o_base_invalid, o_last
// config    | i_cfg_we (no stall) | i_cfg_index, i_cfg_data
//
// Per value, after it is accepted with a valid base: the symbols are checked one by one,
//   then each digit is found by a shared divider that retires 8 dividend bits a cycle
//   and pushed; the sign step is passed whether or not it emits, and the digits follow.
//   An invalid base is reported at once when the length is out of range, or after the
//   symbol check when the length is in range.
// Reset clears the configuration, so the base reads invalid until written.
// A stalled output holds the sequencer at its emit step; input is taken
// only at the idle step, while the last result may still wait in the output.
module signed_radix_formatter #(
    parameter int MAX_BASE    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srf_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [srf_pkg::IN_W-1:0] i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [srf_pkg::SYM_W-1:0]       o_symbol,
    output logic                            o_base_invalid,
    output logic                            o_last
);
    import srf_pkg::*;

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    srf_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    srf_datapath #(
        .MAX_BASE    (MAX_BASE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_ctrl         (w_ctrl),
        .i_value        (i_value),
        .i_out_stall    (i_stall),
        .o_stat         (w_stat),
        .o_out_valid    (o_valid),
        .o_symbol       (o_symbol),
        .o_base_invalid (o_base_invalid),
        .o_last         (o_last)
    );

    assign o_stall = (w_ctrl.op != OP_LOAD);

endmodule

@@ design/srf_ucode_rom.sv @@
// Microcode program of the signed radix formatter: one control word per step.
// Depends on srf_pkg for the word layout, step names and codes.
module srf_ucode_rom (
    input  srf_pkg::t_step  i_step,
    output srf_pkg::t_uword o_word
);
    import srf_pkg::*;

    always_comb begin
        unique case (i_step)
            STEP_IDLE:     o_word = '{op: OP_LOAD,      cond: C_NO_INPUT,  target: STEP_IDLE};
            STEP_LEN:      o_word = '{op: OP_CHK_INIT,  cond: C_LEN_BAD,   target: STEP_INV};
            STEP_SYM:      o_word = '{op: OP_CHK_STEP,  cond: C_CHK_MORE,  target: STEP_SYM};
            STEP_BADQ:     o_word = '{op: OP_NOP,       cond: C_BAD,       target: STEP_INV};
            STEP_DIV_INIT: o_word = '{op: OP_DIV_INIT,  cond: C_NEVER,     target: STEP_IDLE};
            STEP_DIV:      o_word = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  target: STEP_DIV};
            STEP_PUSH:     o_word = '{op: OP_PUSH,      cond: C_MAG_NZ,    target: STEP_DIV_INIT};
            STEP_SIGN:     o_word = '{op: OP_EMIT_SIGN, cond: C_SIGN_WAIT, target: STEP_SIGN};
            STEP_DIG:      o_word = '{op: OP_EMIT_DIG,  cond: C_DIG_LOOP,  target: STEP_DIG};
            STEP_DONE:     o_word = '{op: OP_NOP,       cond: C_ALWAYS,    target: STEP_IDLE};
            STEP_INV:      o_word = '{op: OP_EMIT_INV,  cond: C_OUT_BUSY,  target: STEP_INV};
            STEP_INV_DONE: o_word = '{op: OP_NOP,       cond: C_ALWAYS,    target: STEP_IDLE};
            default:       o_word = '{op: OP_NOP,       cond: C_ALWAYS,    target: STEP_IDLE};
        endcase
    end

endmodule

@@ design/srf_sequencer.sv @@
// Step counter and jump logic of the signed radix formatter.
// Depends on srf_pkg and srf_ucode_rom; drives the datapath control word.
module srf_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  srf_pkg::t_dp_stat i_stat,
    output srf_pkg::t_dp_ctrl o_ctrl
);
    import srf_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_take;

    srf_ucode_rom u_rom (
        .i_step (r_step),
        .o_word (w_word)
    );

    always_comb begin
        case (w_word.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_INPUT:  w_take = !i_in_valid;
            C_LEN_BAD:   w_take = i_stat.len_bad;
            C_CHK_MORE:  w_take = i_stat.chk_more;
            C_BAD:       w_take = i_stat.sym_bad;
            C_DIV_MORE:  w_take = i_stat.div_more;
            C_MAG_NZ:    w_take = i_stat.mag_nz;
            C_SIGN_WAIT: w_take = i_stat.neg && !i_stat.out_free;
            // hold while the output is blocked or digits remain after this one
            C_DIG_LOOP:  w_take = !i_stat.out_free || !i_stat.nd_one;
            C_OUT_BUSY:  w_take = !i_stat.out_free;
            default:     w_take = 1'b1;
        endcase
        n_step = w_take ? w_word.target : r_step + t_step'(1);
        o_ctrl.op     = w_word.op;
        o_ctrl.accept = i_in_valid && (w_word.op == OP_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ design/srf_datapath.sv @@
// Datapath of the signed radix formatter: configuration registers, base check,
// byte-per-cycle divider, digit stack and output register.
// Depends on srf_pkg; controlled by srf_sequencer.
module srf_datapath #(
    parameter int MAX_BASE    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srf_pkg::CFG_W-1:0]    i_cfg_data,
    input  srf_pkg::t_dp_ctrl            i_ctrl,
    input  logic signed [srf_pkg::IN_W-1:0] i_value,
    input  logic                         i_out_stall,
    output srf_pkg::t_dp_stat            o_stat,
    output logic                         o_out_valid,
    output logic [srf_pkg::SYM_W-1:0]    o_symbol,
    output logic                         o_base_invalid,
    output logic                         o_last
);
    import srf_pkg::*;

    localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W     = DIV_STEPS * DIV_BITS;
    localparam int DC_W      = $clog2(DIV_STEPS + 1);
    localparam int DIG_W     = $clog2(MAX_BASE);
    localparam int ND_W      = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W     = $clog2(VALUE_WIDTH);

    logic [LEN_W-1:0]  r_base_len;
    logic [SYMS_W-1:0] r_sym_lo;
    logic [SYMS_W-1:0] r_sym_hi;

    logic [PAD_W-1:0]     r_mag;
    logic                 r_neg;
    logic [DIG_W-1:0]     r_rem;
    logic [DC_W-1:0]      r_cnt;
    logic [SYM_IDX_W-1:0] r_chk_i;
    logic                 r_bad;
    logic [ND_W-1:0]      r_nd;
    logic [DIG_W-1:0]     r_dig [VALUE_WIDTH];

    logic             r_out_valid;
    logic [SYM_W-1:0] r_symbol;
    logic             r_inval;
    logic             r_last;

    logic [SYM_W-1:0]       w_sym [SYM_N];
    logic [2*SYMS_W-1:0]    w_bank;
    logic [SYM_W-1:0]       w_chk_sym;
    logic                   w_chk_bad;
    logic [VALUE_WIDTH-1:0] w_v;
    logic [VALUE_WIDTH-1:0] w_abs;
    logic [PAD_W-1:0]       n_mag;
    logic [DIG_W-1:0]       n_rem;
    logic [DIV_BITS-1:0]    w_qbits;
    logic [DIV_BITS-1:0]    w_top;
    logic [5:0]             w_t;
    logic [ND_W-1:0]        w_nd_dec;
    logic [DIG_W-1:0]       w_top_dig;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_pop;

    // symbol table view of the two banks
    always_comb begin
        w_bank = {r_sym_hi, r_sym_lo};
        for (int k = 0; k < SYM_N; k++) begin
            w_sym[k] = w_bank[k*SYM_W +: SYM_W];
        end
    end

    // symbol under check: a sign, or repeated later within the used range
    always_comb begin
        w_chk_sym = w_sym[r_chk_i];
        w_chk_bad = (w_chk_sym == SYM_PLUS) || (w_chk_sym == SYM_MINUS);
        for (int j = 0; j < SYM_N; j++) begin
            if ((LEN_W'(j) > {1'b0, r_chk_i}) && (LEN_W'(j) < r_base_len) &&
                (w_sym[j] == w_chk_sym)) begin
                w_chk_bad = 1'b1;
            end
        end
    end

    // magnitude of the low VALUE_WIDTH bits; the minimum value maps onto itself
    always_comb begin
        w_v   = i_value[VALUE_WIDTH-1:0];
        w_abs = w_v[VALUE_WIDTH-1] ? (~w_v + VALUE_WIDTH'(1)) : w_v;
    end

    // retire one byte of the dividend: restoring steps on the narrow remainder
    always_comb begin
        w_top   = r_mag[PAD_W-1 -: DIV_BITS];
        n_rem   = r_rem;
        w_qbits = '0;
        w_t     = '0;
        for (int k = DIV_BITS - 1; k >= 0; k--) begin
            w_t = 6'({n_rem, w_top[k]});
            if (w_t >= {1'b0, r_base_len}) begin
                w_qbits[k] = 1'b1;
                n_rem      = DIG_W'(w_t - {1'b0, r_base_len});
            end else begin
                n_rem = DIG_W'(w_t);
            end
        end
        n_mag = (r_mag << DIV_BITS) | PAD_W'(w_qbits);
    end

    always_comb begin
        w_nd_dec   = r_nd - ND_W'(1);
        w_top_dig  = r_dig[w_nd_dec[IDX_W-1:0]];
        w_out_free = !r_out_valid || !i_out_stall;
        w_pop      = w_out_free && (i_ctrl.op == OP_EMIT_DIG);
        w_emit     = w_out_free && ((i_ctrl.op == OP_EMIT_DIG) ||
                                    (i_ctrl.op == OP_EMIT_INV) ||
                                    ((i_ctrl.op == OP_EMIT_SIGN) && r_neg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= '0;
            r_sym_lo   <= '0;
            r_sym_hi   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE_LENGTH:  r_base_len <= i_cfg_data[LEN_W-1:0];
                REG_SYMBOLS_LOW:  r_sym_lo   <= i_cfg_data[SYMS_W-1:0];
                REG_SYMBOLS_HIGH: r_sym_hi   <= i_cfg_data[SYMS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd <= '0;
        end else begin
            unique case (i_ctrl.op)
                OP_NOP:       ;
                OP_LOAD: begin
                    if (i_ctrl.accept) begin
                        r_mag <= PAD_W'(w_abs);
                        r_neg <= w_v[VALUE_WIDTH-1];
                        r_nd  <= '0;
                    end
                end
                OP_CHK_INIT: begin
                    r_chk_i <= '0;
                    r_bad   <= 1'b0;
                end
                OP_CHK_STEP: begin
                    r_bad   <= r_bad | w_chk_bad;
                    r_chk_i <= r_chk_i + SYM_IDX_W'(1);
                end
                OP_DIV_INIT: begin
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                OP_DIV_STEP: begin
                    r_mag <= n_mag;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + DC_W'(1);
                end
                OP_PUSH: begin
                    r_dig[r_nd[IDX_W-1:0]] <= r_rem;
                    r_nd <= r_nd + ND_W'(1);
                end
                OP_EMIT_SIGN: ;
                OP_EMIT_DIG: begin
                    if (w_pop) begin
                        r_nd <= w_nd_dec;
                    end
                end
                OP_EMIT_INV:  ;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            case (i_ctrl.op)
                OP_EMIT_DIG: begin
                    r_symbol <= w_sym[SYM_IDX_W'(w_top_dig)];
                    r_inval  <= 1'b0;
                    r_last   <= (r_nd == ND_W'(1));
                end
                OP_EMIT_SIGN: begin
                    r_symbol <= SYM_MINUS;
                    r_inval  <= 1'b0;
                    r_last   <= 1'b0;
                end
                default: begin
                    r_symbol <= '0;
                    r_inval  <= 1'b1;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.len_bad  = (r_base_len < LEN_W'(2)) || (int'(r_base_len) > MAX_BASE);
        o_stat.sym_bad  = r_bad;
        o_stat.chk_more = (({1'b0, r_chk_i} + LEN_W'(1)) < r_base_len);
        o_stat.div_more = ((int'(r_cnt) + 1) < DIV_STEPS);
        o_stat.mag_nz   = |r_mag;
        o_stat.out_free = w_out_free;
        o_stat.neg      = r_neg;
        o_stat.nd_one   = (r_nd == ND_W'(1));
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_symbol;
    assign o_base_invalid = r_inval;
    assign o_last         = r_last;

endmodule
